[design/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro clocks on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/cdt_pkg.sv]
// Countdown timer package: mode and opcode codes, constants, saturating helpers.
// No dependencies; imported by the timer controller and its checker.
`timescale 1ns / 1ps
`default_nettype none

package cdt_pkg;

  localparam int unsigned DataW = 16;

  typedef logic [DataW-1:0] data_t;
  typedef logic [1:0] mode_t;
  typedef logic [3:0] opcode_t;

  localparam mode_t MODE_SET   = 2'd0;
  localparam mode_t MODE_RUN   = 2'd1;
  localparam mode_t MODE_PAUSE = 2'd2;
  localparam mode_t MODE_RING  = 2'd3;

  localparam opcode_t OP_SERVICE  = 4'd0;
  localparam opcode_t OP_PRESS    = 4'd1;
  localparam opcode_t OP_LONG     = 4'd2;
  localparam opcode_t OP_CW       = 4'd3;
  localparam opcode_t OP_CCW      = 4'd4;
  localparam opcode_t OP_CW_FAST  = 4'd5;
  localparam opcode_t OP_CCW_FAST = 4'd6;
  localparam opcode_t OP_TICK     = 4'd7;

  localparam data_t RING_TIMEOUT_RESET = 16'd10000;

  // coarse stepping starts at one hour
  localparam data_t COARSE_THRESHOLD = 16'd3600;
  localparam logic [8:0] STEP_FINE   = 9'd1;
  localparam logic [8:0] STEP_COARSE = 9'd60;
  localparam logic [8:0] SNAP_FINE   = 9'd5;
  localparam logic [8:0] SNAP_COARSE = 9'd300;

  // reciprocals: x/5 = (x*3277)>>14 exact for 12-bit x,
  // x/300 ~ (x*55924)>>24, low by at most one
  localparam logic [11:0] RECIP_FINE   = 12'd3277;
  localparam logic [15:0] RECIP_COARSE = 16'd55924;

  function automatic data_t sat_up(data_t v, logic [8:0] m);
    logic [DataW:0] s;
    s = {1'b0, v} + {{(DataW-8){1'b0}}, m};
    return s[DataW] ? {DataW{1'b1}} : s[DataW-1:0];
  endfunction

  function automatic data_t sat_dn(data_t v, logic [8:0] m);
    data_t mw;
    mw = {{(DataW-9){1'b0}}, m};
    return (v < mw) ? '0 : v - mw;
  endfunction

endpackage

`default_nettype wire

[design/countdown_timer_controller.sv]
// Countdown timer controller: mode sequencing, target and countdown update.
// Depends on cdt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one event per clock cycle unless the output stalls, and returns one
// status result per event. An event is held in the input register; when it
// advances, the mode, target and remaining-seconds registers are updated
// from it and the status is loaded into the result register at that edge.
// The rate is set by the state update loop, whose next-state logic (rotation
// step, saturating add, mode decode) is combinational. The result register
// and the input register each hold one request, so a stalled output leaves
// room for one more event. ring_timeout is written with cfg_we.
module countdown_timer_controller
  import cdt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  opcode,
  input  wire logic [15:0] now_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       mode,
  output logic [15:0]      target_seconds,
  output logic [15:0]      seconds_left,
  output logic             idle
);

  data_t   ring_timeout;
  mode_t   mode_state, mode_next;
  data_t   target, target_next;
  data_t   left_sec, left_next;
  data_t   last_change, last_change_next;

  logic    s1_valid;
  opcode_t s1_opcode;
  data_t   s1_now;
  logic    advance;

  // rotation step
  logic        coarse;
  logic [23:0] prod_fine;
  logic [9:0]  q_fine;
  logic [11:0] q_fine_x5;
  logic [2:0]  rem_fine;
  logic [31:0] prod_coarse;
  logic [7:0]  q_coarse;
  data_t       q_coarse_x300;
  data_t       diff_coarse;
  logic [8:0]  rem_coarse;
  logic [8:0]  rem, snap, base, step_mag;
  logic        step_up;
  logic        is_rot;
  data_t       elapsed;
  data_t       left_dec;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_timeout <= RING_TIMEOUT_RESET;
    end else if (cfg_we) begin
      ring_timeout <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode <= opcode;
      s1_now    <= now_ms;
    end
  end

  // remainder of target by the snap size
  always_comb begin
    coarse        = (target >= COARSE_THRESHOLD);
    prod_fine     = {12'd0, target[11:0]} * {12'd0, RECIP_FINE};
    q_fine        = prod_fine[23:14];
    q_fine_x5     = 12'({2'b0, q_fine} * 12'(SNAP_FINE));
    rem_fine      = 3'(target[11:0] - q_fine_x5);
    prod_coarse   = {16'd0, target} * {16'd0, RECIP_COARSE};
    q_coarse      = prod_coarse[31:24];
    q_coarse_x300 = 16'({8'd0, q_coarse} * {7'd0, SNAP_COARSE});
    diff_coarse   = target - q_coarse_x300;
    rem_coarse    = (diff_coarse >= {7'd0, SNAP_COARSE})
                    ? 9'(diff_coarse - {7'd0, SNAP_COARSE}) : diff_coarse[8:0];
    rem  = coarse ? rem_coarse : {6'd0, rem_fine};
    snap = coarse ? SNAP_COARSE : SNAP_FINE;
    base = coarse ? STEP_COARSE : STEP_FINE;

    is_rot   = 1'b1;
    step_up  = 1'b0;
    step_mag = '0;
    case (s1_opcode)
      OP_CW: begin
        step_up  = 1'b1;
        step_mag = base;
      end
      OP_CCW: begin
        step_mag = base;
      end
      OP_CW_FAST: begin
        step_up  = 1'b1;
        step_mag = snap - rem;
      end
      OP_CCW_FAST: begin
        // strictly previous multiple: a full snap when already aligned, no step at zero
        if (target == '0) begin
          step_mag = '0;
        end else begin
          step_mag = (rem == '0) ? snap : rem;
        end
      end
      default: begin
        is_rot = 1'b0;
      end
    endcase
  end

  assign elapsed  = s1_now - last_change;
  assign left_dec = (left_sec == '0) ? '0 : left_sec - 16'd1;

  always_comb begin
    mode_next        = mode_state;
    target_next      = target;
    left_next        = left_sec;
    last_change_next = last_change;
    unique case (mode_state)
      MODE_SET: begin
        if (s1_opcode == OP_PRESS) begin
          if (target != '0) begin
            left_next        = target;
            mode_next        = MODE_RUN;
            last_change_next = s1_now;
          end
        end else if (is_rot) begin
          target_next = step_up ? sat_up(target, step_mag) : sat_dn(target, step_mag);
        end else if (s1_opcode == OP_LONG && target == '0) begin
          left_next        = '0;
          last_change_next = s1_now;
        end
      end
      MODE_RUN, MODE_PAUSE: begin
        if (s1_opcode == OP_PRESS) begin
          mode_next        = (mode_state == MODE_RUN) ? MODE_PAUSE : MODE_RUN;
          last_change_next = s1_now;
        end else if (is_rot) begin
          target_next = step_up ? sat_up(target, step_mag) : sat_dn(target, step_mag);
          left_next   = step_up ? sat_up(left_sec, step_mag) : sat_dn(left_sec, step_mag);
        end else if (s1_opcode == OP_LONG) begin
          target_next      = '0;
          left_next        = '0;
          mode_next        = MODE_SET;
          last_change_next = s1_now;
        end else if (s1_opcode == OP_TICK && mode_state == MODE_RUN) begin
          left_next = left_dec;
          if (left_dec == '0) begin
            mode_next        = MODE_RING;
            last_change_next = s1_now;
          end
        end
      end
      MODE_RING: begin
        if (s1_opcode == OP_PRESS || s1_opcode == OP_LONG
            || (s1_opcode == OP_SERVICE && elapsed >= ring_timeout)) begin
          target_next      = '0;
          left_next        = '0;
          mode_next        = MODE_SET;
          last_change_next = s1_now;
        end
      end
      default: begin
        mode_next = MODE_SET;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state  <= MODE_SET;
      target      <= '0;
      left_sec    <= '0;
      last_change <= '0;
    end else if (advance) begin
      mode_state  <= mode_next;
      target      <= target_next;
      left_sec    <= left_next;
      last_change <= last_change_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode           <= mode_next;
      target_seconds <= target_next;
      seconds_left   <= left_next;
      idle           <= (mode_next == MODE_SET) && (target_next == '0);
    end
  end

endmodule

`default_nettype wire

[design/cdt_checker.sv]
// Port-level checker for the countdown timer controller, bound to that module.
// Depends on cdt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cdt_checker
  import cdt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  mode,
  input wire logic [15:0] target_seconds,
  input wire logic [15:0] seconds_left,
  input wire logic        idle
);

  // a stalled result stays put
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode) && $stable(target_seconds) && $stable(seconds_left), "result changed while stalled")

  `ASSERT_ALWAYS(a_idle_flag, !out_valid || (idle == ((mode == MODE_SET) && (target_seconds == 16'd0))), "idle flag disagrees with mode and target")

  // set-time mode never carries a countdown
  `ASSERT_ALWAYS(a_set_no_left, !out_valid || mode != MODE_SET || seconds_left == 16'd0, "seconds left nonzero in set-time mode")

  `ASSERT_ALWAYS(a_ring_zero, !out_valid || mode != MODE_RING || seconds_left == 16'd0, "ringing with seconds left")

endmodule

bind countdown_timer_controller cdt_checker u_cdt_checker (.*);

`default_nettype wire
